>>> rtl/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants of the tree-walk bit decoder
// Holds the command codes, register indexes, item and node layouts, the
// controller state type and the command and status groups between modules.
// ----------------------------------------------------------------------------
package htbd_pkg;

  // Number of entries in the node table.
  localparam int NODE_COUNT = 512;
  localparam int NODE_AW    = $clog2(NODE_COUNT);

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = 32;
  localparam int BYTE_W = 8;
  localparam int BIT_W  = $clog2(BYTE_W);
  localparam int CFG_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DECODE  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_ROOT_NODE  = 1'b0,
    CFG_TOTAL_BITS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  node_index;
    logic              node_is_leaf;
    logic [SYM_W-1:0]  node_symbol;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    logic             last_of_byte;
    logic             stream_done;
  } out_item_t;

  typedef struct packed {
    logic             is_leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_END
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic restart;
    logic begin_byte;
    logic rd_cur;
    logic step;
    logic check;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fin;
    logic leaf;
    logic last_bit;
  } dp_status_t;

endpackage

>>> rtl/htbd_datapath.sv
// ----------------------------------------------------------------------------
// htbd_datapath: node table, walk registers and result register
// Stores the node table, follows child links one bit at a time, counts bits
// and holds back each symbol until it is known whether it ends the byte.
// ----------------------------------------------------------------------------
module htbd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htbd_pkg::in_item_t  item_i,
  input  htbd_pkg::dp_cmd_t   cmd_i,
  output htbd_pkg::dp_status_t status_o,
  input  logic                cfg_valid_i,
  input  htbd_pkg::cfg_idx_e  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                result_valid_o,
  output htbd_pkg::out_item_t result_o
);
  import htbd_pkg::*;

  node_t mem [NODE_COUNT];
  node_t rdata_q;

  logic [IDX_W-1:0]  cur_q, cur_d, root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, total_q, total_d, cnt_inc;
  logic              fin_q, fin_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
  logic              pend_done_q, pend_done_d;
  out_item_t         out_q, out_d;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr, next_idx;

  assign next_idx = byte_q[bit_q] ? rdata_q.right : rdata_q.left;
  assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + CNT_W'(1);

  assign rd_en   = cmd_i.rd_cur | cmd_i.step | (cmd_i.check & rdata_q.is_leaf);
  assign rd_addr = cmd_i.rd_cur ? cur_q : (cmd_i.step ? next_idx : root_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[item_i.node_index[NODE_AW-1:0]] <= '{is_leaf: item_i.node_is_leaf,
                                               symbol:  item_i.node_symbol,
                                               left:    item_i.left_index,
                                               right:   item_i.right_index};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr[NODE_AW-1:0]];
    end
  end

  always_comb begin
    cur_d        = cur_q;
    root_d       = root_q;
    cnt_d        = cnt_q;
    total_d      = total_q;
    fin_d        = fin_q;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = 1'b0;
    byte_d       = byte_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    out_d        = out_q;

    // Writing the root also moves the walk to the new root.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROOT_NODE: begin
          root_d = cfg_data_i[IDX_W-1:0];
          cur_d  = cfg_data_i[IDX_W-1:0];
        end
        CFG_TOTAL_BITS: total_d = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.restart) begin
      cur_d = root_q;
      cnt_d = '0;
      fin_d = 1'b0;
    end

    if (cmd_i.begin_byte) begin
      byte_d       = item_i.data_byte;
      bit_d        = '0;
      pend_valid_d = 1'b0;
    end

    if (cmd_i.step) begin
      cur_d = next_idx;
      cnt_d = cnt_inc;
      fin_d = (cnt_inc >= total_q);
    end

    // A new symbol releases the one held before it, which then is not last.
    if (cmd_i.check) begin
      bit_d = bit_q + BIT_W'(1);
      if (rdata_q.is_leaf) begin
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d = '{symbol: pend_sym_q, symbol_valid: 1'b1,
                    last_of_byte: 1'b0, stream_done: pend_done_q};
        end
        pend_valid_d = 1'b1;
        pend_sym_d   = rdata_q.symbol;
        pend_done_d  = fin_q;
        cur_d        = root_q;
      end
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_d = '{symbol: pend_sym_q, symbol_valid: 1'b1,
                  last_of_byte: 1'b1, stream_done: pend_done_q};
      end else begin
        out_d = '{symbol: '0, symbol_valid: 1'b0,
                  last_of_byte: 1'b1, stream_done: fin_q};
      end
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      root_q       <= '0;
      cnt_q        <= '0;
      total_q      <= CNT_W'(1);
      fin_q        <= 1'b0;
      bit_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_q        <= cur_d;
      root_q       <= root_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
      fin_q        <= fin_d;
      bit_q        <= bit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_sym_q  <= pend_sym_d;
    pend_done_q <= pend_done_d;
    out_q       <= out_d;
  end

  assign status_o = '{fin: fin_q, leaf: rdata_q.is_leaf,
                      last_bit: (bit_q == BIT_W'(BYTE_W - 1))};

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

>>> rtl/htbd_ctrl.sv
// ----------------------------------------------------------------------------
// htbd_ctrl: sequencer of the tree-walk bit decoder
// Takes commands, steps through the bits of a coded byte and closes the byte.
// ----------------------------------------------------------------------------
module htbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  htbd_pkg::cmd_e       cmd_i,
  input  htbd_pkg::dp_status_t status_i,
  output htbd_pkg::dp_cmd_t    dp_cmd_o
);
  import htbd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    busy     = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_LOAD:    dp_cmd_o.load = 1'b1;
            CMD_RESTART: dp_cmd_o.restart = 1'b1;
            CMD_DECODE: begin
              dp_cmd_o.begin_byte = 1'b1;
              if (status_i.fin) begin
                state_d = ST_END;
              end else begin
                dp_cmd_o.rd_cur = 1'b1;
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        dp_cmd_o.step = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        dp_cmd_o.check = 1'b1;
        if (status_i.fin || status_i.last_bit) begin
          state_d = ST_END;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_END: begin
        dp_cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/huffman_tree_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_top: table-driven prefix code decoder
// Walks a loaded node table one coded bit at a time and emits symbols.
// ----------------------------------------------------------------------------
// Usage:
// An item is transferred when start is high and busy is low. A load item
// writes one node of the table, a restart item returns the walk to the root
// and clears the bit count; neither gives a result.
// A decode item consumes its byte least significant bit first. Each bit
// is taken by reading the current node and following a child, then by
// looking at the child it reached, both through the single read port of
// the node table.
// Results leave on result_o, each for exactly one cycle while result_valid_o
// is high; a decode item always gives at least one, with last_of_byte on the
// final one. The receiver cannot stall the results.
// Configuration writes transfer on the cfg channel whenever cfg_valid_i is
// high (cfg_ready_o is always high) and must only be issued while busy is low.
// Reset sets the root to entry 0, total_bits to 1 and clears the bit count;
// the node table holds no defined contents until it is loaded.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  htbd_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output htbd_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  htbd_pkg::cfg_idx_e  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import htbd_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Registers accept a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the bits of a byte.
  htbd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (item_i.cmd),
    .status_i (dp_status),
    .dp_cmd_o (dp_cmd)
  );

  // The datapath holds the table, the walk state and the result register.
  htbd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
